// ===== rtl/tslm_pkg.sv =====
// ----------------------------------------------------------------------------
// tslm_pkg
// Shared constants, types, tanh table and control program of the soft clipper.
// ----------------------------------------------------------------------------
package tslm_pkg;

	// stream and filter sizes
	localparam int SAMPLE_BITS = 24;
	localparam int CHANNELS    = 8;
	localparam int CH_W        = 3;
	localparam int CH_IDX_W    = $clog2(CHANNELS);
	localparam int TDATA_W     = ((SAMPLE_BITS + 7) / 8) * 8;
	localparam int TUSER_W     = CH_W;

	// tanh table: TAB_DEPTH + 1 points over [0,8], Q0.30
	localparam int TAB_DEPTH = 1024;
	localparam int TAB_AW    = $clog2(TAB_DEPTH);
	localparam int TAB_N     = TAB_DEPTH + 1;
	localparam int ROM_AW    = TAB_AW + 1;
	localparam int TAB_W     = 30;
	localparam int IDX_SHIFT = 50 - TAB_AW;
	localparam int FRAC_W    = 26 - TAB_AW;

	// datapath widths
	localparam int MUL_A_W = 42;
	localparam int MUL_B_W = 23;
	localparam int ACC_W   = 64;
	localparam int W_W     = 34;
	localparam int MIX_W   = 35;
	localparam int OUT_SH  = 32 - SAMPLE_BITS;

	localparam logic signed [ACC_W-1:0] RND16     = 64'sd32768;
	localparam logic signed [ACC_W-1:0] WRAP_CORR = 64'sd1 <<< 38;
	localparam logic signed [ACC_W-1:0] INT32_HI  = 64'sd2147483647;
	localparam logic signed [ACC_W-1:0] INT32_LO  = -64'sd2147483648;
	localparam logic signed [ACC_W-1:0] OUT_RND   = (64'sd1 <<< OUT_SH) >>> 1;
	localparam logic signed [ACC_W-1:0] SAT_HI    = (64'sd1 <<< (SAMPLE_BITS - 1)) - 64'sd1;
	localparam logic signed [ACC_W-1:0] SAT_LO    = -(64'sd1 <<< (SAMPLE_BITS - 1));

	// configuration registers
	localparam int CFG_IDX_W  = 4;
	localparam int CFG_DATA_W = 22;
	localparam int DRIVE_W    = 22;
	localparam int OGAIN_W    = 18;
	localparam int FB_W       = 16;
	localparam int WET_W      = 17;

	localparam logic [CFG_IDX_W-1:0] CFG_DRIVE_GAIN      = 4'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_OUTPUT_GAIN     = 4'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_LOWPASS_FEEDBACK = 4'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_WET_MIX         = 4'd3;

	localparam logic [DRIVE_W-1:0] DRIVE_RST = 22'd260903;
	localparam logic [OGAIN_W-1:0] OGAIN_RST = 18'd65536;
	localparam logic [FB_W-1:0]    FB_RST    = 16'd22997;
	localparam logic [WET_W-1:0]   WET_RST   = 17'd65536;
	localparam logic [WET_W-1:0]   UNITY_Q16 = 17'd65536;

	// control program
	typedef enum logic [3:0] {
		ST_MDRV, ST_ADDR, ST_LO, ST_HI, ST_MINT, ST_SHAP, ST_MFF, ST_MFB,
		ST_ZST, ST_MOG, ST_WST, ST_MDRY, ST_MWET, ST_MIXR, ST_OUT
	} step_t;

	typedef enum logic [2:0] {A_S31, A_DIFF, A_Y31, A_MEM, A_Z, A_W} a_sel_t;
	typedef enum logic [2:0] {B_DRIVE, B_FRAC, B_FF, B_FB, B_OG, B_DRY, B_WET} b_sel_t;
	typedef enum logic [1:0] {ACC_HOLD, ACC_LOAD, ACC_ADD} acc_op_t;
	typedef enum logic [3:0] {
		ACT_NONE, ACT_ADDR, ACT_LO, ACT_HI, ACT_SHAPE, ACT_ZST, ACT_WST, ACT_MIXR, ACT_OUT
	} act_t;

	typedef struct packed {
		a_sel_t  a_sel;
		b_sel_t  b_sel;
		acc_op_t acc_op;
		act_t    act;
		logic    jmp_bypass;
		step_t   tgt;
		logic    last;
	} ctl_t;

	typedef logic [TAB_W-1:0] tab_t [TAB_N];

	function automatic ctl_t ucode(input step_t step);
		ctl_t c;
		c = '0;
		case (step)
			ST_MDRV: begin
				c.a_sel = A_S31; c.b_sel = B_DRIVE; c.acc_op = ACC_LOAD;
				c.jmp_bypass = 1'b1; c.tgt = ST_OUT;
			end
			ST_ADDR: c.act = ACT_ADDR;
			ST_LO:   c.act = ACT_LO;
			ST_HI:   c.act = ACT_HI;
			ST_MINT: begin
				c.a_sel = A_DIFF; c.b_sel = B_FRAC; c.acc_op = ACC_LOAD;
			end
			ST_SHAP: c.act = ACT_SHAPE;
			ST_MFF: begin
				c.a_sel = A_Y31; c.b_sel = B_FF; c.acc_op = ACC_LOAD;
			end
			ST_MFB: begin
				c.a_sel = A_MEM; c.b_sel = B_FB; c.acc_op = ACC_ADD;
			end
			ST_ZST:  c.act = ACT_ZST;
			ST_MOG: begin
				c.a_sel = A_Z; c.b_sel = B_OG; c.acc_op = ACC_LOAD;
			end
			ST_WST:  c.act = ACT_WST;
			ST_MDRY: begin
				c.a_sel = A_S31; c.b_sel = B_DRY; c.acc_op = ACC_LOAD;
			end
			ST_MWET: begin
				c.a_sel = A_W; c.b_sel = B_WET; c.acc_op = ACC_ADD;
			end
			ST_MIXR: c.act = ACT_MIXR;
			ST_OUT: begin
				c.act = ACT_OUT; c.last = 1'b1;
			end
			default: c = '0;
		endcase
		return c;
	endfunction

	// shift-and-subtract quotient for the table build, quotient below 2^qbits
	function automatic longint unsigned udiv(input longint unsigned num,
			input longint unsigned den, input int qbits);
		longint unsigned rem;
		longint unsigned quo;
		rem = num;
		quo = '0;
		for (int i = qbits - 1; i >= 0; i--) begin
			if ((rem >> i) >= den) begin
				rem = rem - (den << i);
				quo = quo | (64'd1 << i);
			end
		end
		return quo;
	endfunction

	// tanh(8k/D) via e^(-2x) = (e^(-x/16))^32, taylor series for the inner term
	function automatic tab_t tanh_table();
		tab_t              t;
		longint unsigned   one31;
		longint unsigned   a;
		longint unsigned   term;
		longint unsigned   u;
		longint unsigned   q;
		longint            sum;
		longint unsigned   n;
		one31 = 64'd1 << 31;
		for (int k = 0; k < TAB_N; k++) begin
			a    = (longint'(k) << 31) / (2 * TAB_DEPTH);
			sum  = longint'(one31);
			term = one31;
			for (n = 1; n <= 12; n++) begin
				term = udiv((term * a) >> 31, n, 32);
				if (n[0]) sum = sum - longint'(term);
				else sum = sum + longint'(term);
			end
			u = longint'(sum);
			for (int i = 0; i < 5; i++) u = (u * u) >> 31;
			q = udiv(((one31 - u) << 30) + ((one31 + u) >> 1), one31 + u, 32);
			t[k] = q[TAB_W-1:0];
		end
		return t;
	endfunction

endpackage

// ===== rtl/tslm_tanh_rom.sv =====
// ----------------------------------------------------------------------------
// tslm_tanh_rom
// Tanh lookup rom, one registered read per cycle.
// ----------------------------------------------------------------------------
module tslm_tanh_rom import tslm_pkg::*; (
	input  logic              clk,
	input  logic [ROM_AW-1:0] addr,
	output logic [TAB_W-1:0]  data_q
);

	localparam tab_t ROM = tanh_table();

	always_ff @(posedge clk) begin
		data_q <= ROM[addr];
	end

endmodule

// ===== rtl/tanh_saturator_lowpass_mix.sv =====
// ----------------------------------------------------------------------------
// tanh_saturator_lowpass_mix
// Tanh soft clipper, per-channel one-pole low-pass, makeup gain, dry/wet mix.
// ----------------------------------------------------------------------------
// Input words arrive on s_axis with the sample in tdata and the channel in
// tuser; each input word yields exactly one output word on m_axis carrying the
// processed sample and the same channel.
// Gains, filter feedback and wet share are written on the cfg channel
// (index 0 drive, 1 output gain, 2 feedback, 3 wet mix); the user must write
// them only while no word is in flight, as the block does not enforce it.
// cfg_ready is always high and unknown indexes are ignored. One shared
// multiplier runs a 15-step control program per word, so the block takes
// the next word only while idle or in the program's last step. A channel
// outside the filter bank jumps straight to the last step, echoed unchanged.
// The result sits in an output register: the next word is taken while it
// waits, and the program holds in its last step while the receiver stalls
// and the output register is still full.
// Reset restores the register defaults and zeroes all filter memories at
// once; the block is ready as soon as reset is released.
// ----------------------------------------------------------------------------
module tanh_saturator_lowpass_mix import tslm_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_axis_tvalid,
	output logic                  s_axis_tready,
	input  logic [TDATA_W-1:0]    s_axis_tdata,   // [23:0] sample_in
	input  logic [TUSER_W-1:0]    s_axis_tuser,   // [2:0] channel
	output logic                  m_axis_tvalid,
	input  logic                  m_axis_tready,
	output logic [TDATA_W-1:0]    m_axis_tdata,   // [23:0] sample_out
	output logic [TUSER_W-1:0]    m_axis_tuser,   // [2:0] channel_out
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	logic [DRIVE_W-1:0] drive_q;
	logic [OGAIN_W-1:0] ogain_q;
	logic [FB_W-1:0]    fb_q;
	logic [WET_W-1:0]   wet_q;

	logic  busy_q, busy_n;
	step_t step_q, step_n;
	ctl_t  ctl;
	logic  adv;
	logic  accept;
	logic  out_free;

	logic signed [SAMPLE_BITS-1:0] sample_q;
	logic [CH_W-1:0]               ch_q;
	logic                          ch_ok;

	logic signed [ACC_W-1:0]   acc_q;
	logic [ROM_AW-1:0]         idx_q;
	logic [FRAC_W-1:0]         frac_q;
	logic                      neg_q;
	logic [TAB_W-1:0]          lo_q;
	logic signed [TAB_W:0]     diff_q;
	logic signed [MUL_A_W-1:0] y31_q;
	logic signed [31:0]        z_q;
	logic signed [W_W-1:0]     w_q;
	logic signed [MIX_W-1:0]   mix_q;
	logic signed [31:0]        mem_q [CHANNELS];

	logic                      out_valid_q;
	logic [SAMPLE_BITS-1:0]    out_data_q;
	logic [CH_W-1:0]           out_ch_q;

	logic [ROM_AW-1:0]         rom_addr;
	logic [TAB_W-1:0]          rom_q;

	logic signed [31:0]                s31;
	logic [WET_W-1:0]                  wet_eff;
	logic [WET_W-1:0]                  dry;
	logic [WET_W-1:0]                  ff;
	logic signed [31:0]                mem_rd;
	logic signed [MUL_A_W-1:0]         mul_a;
	logic signed [MUL_B_W-1:0]         mul_b;
	logic signed [MUL_A_W+MUL_B_W-1:0] prod;
	logic signed [ACC_W-1:0]           acc_rnd;
	logic [ACC_W-1:0]                  mag;
	logic [ACC_W-IDX_SHIFT-1:0]        idx_full;
	logic                              over;
	logic [ROM_AW-1:0]                 addr_first;
	logic [ROM_AW-1:0]                 addr_next;
	logic signed [ACC_W-1:0]           y_v;
	logic signed [ACC_W-1:0]           y2_v;
	logic signed [ACC_W-1:0]           y31_v;
	logic signed [31:0]                z_v;
	logic signed [ACC_W-1:0]           res_v;
	logic signed [ACC_W-1:0]           sat_v;

	tslm_tanh_rom u_rom (
		.clk    (clk),
		.addr   (rom_addr),
		.data_q (rom_q)
	);

	assign ctl      = ucode(step_q);
	assign out_free = !out_valid_q || m_axis_tready;
	assign adv      = busy_q && (ctl.act != ACT_OUT || out_free);
	assign accept   = s_axis_tvalid && s_axis_tready;
	assign ch_ok    = 32'(ch_q) < CHANNELS;

	assign s_axis_tready = !busy_q || (ctl.last && out_free);
	assign cfg_ready     = 1'b1;
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = TDATA_W'(out_data_q);
	assign m_axis_tuser  = out_ch_q;

	// sequencer
	always_comb begin
		busy_n = busy_q;
		step_n = step_q;
		if (busy_q) begin
			if (ctl.last) begin
				if (out_free) begin
					busy_n = accept;
					step_n = ST_MDRV;
				end
			end else if (ctl.jmp_bypass && !ch_ok) begin
				step_n = ctl.tgt;
			end else begin
				step_n = step_t'(step_q + 4'd1);
			end
		end else if (accept) begin
			busy_n = 1'b1;
			step_n = ST_MDRV;
		end
	end

	// operands of the shared multiplier
	assign s31     = 32'(sample_q) <<< OUT_SH;
	assign wet_eff = (wet_q > UNITY_Q16) ? UNITY_Q16 : wet_q;
	assign dry     = UNITY_Q16 - wet_eff;
	assign ff      = UNITY_Q16 - WET_W'(fb_q);
	assign mem_rd  = mem_q[ch_q[CH_IDX_W-1:0]];

	always_comb begin
		case (ctl.a_sel)
			A_S31:   mul_a = MUL_A_W'(s31);
			A_DIFF:  mul_a = MUL_A_W'(diff_q);
			A_Y31:   mul_a = y31_q;
			A_MEM:   mul_a = MUL_A_W'(mem_rd);
			A_Z:     mul_a = MUL_A_W'(z_q);
			A_W:     mul_a = MUL_A_W'(w_q);
			default: mul_a = '0;
		endcase
		case (ctl.b_sel)
			B_DRIVE: mul_b = MUL_B_W'(drive_q);
			B_FRAC:  mul_b = MUL_B_W'(frac_q);
			B_FF:    mul_b = MUL_B_W'(ff);
			B_FB:    mul_b = MUL_B_W'(fb_q);
			B_OG:    mul_b = MUL_B_W'(ogain_q);
			B_DRY:   mul_b = MUL_B_W'(dry);
			B_WET:   mul_b = MUL_B_W'(wet_eff);
			default: mul_b = '0;
		endcase
	end

	assign prod    = mul_a * mul_b;
	assign acc_rnd = (acc_q + RND16) >>> 16;

	// table index and fraction from |drive * sample|
	assign mag        = acc_q[ACC_W-1] ? ACC_W'(-acc_q) : ACC_W'(acc_q);
	assign idx_full   = mag[ACC_W-1:IDX_SHIFT];
	assign over       = idx_full >= (ACC_W - IDX_SHIFT)'(TAB_DEPTH);
	assign addr_first = over ? ROM_AW'(TAB_DEPTH) : ROM_AW'(idx_full[TAB_AW-1:0]);
	assign addr_next  = (idx_q == ROM_AW'(TAB_DEPTH)) ? idx_q : idx_q + 1'b1;
	assign rom_addr   = (ctl.act == ACT_LO) ? addr_next : addr_first;

	// interpolation; a falling segment wraps like unsigned 64-bit math
	always_comb begin
		y_v = $signed(ACC_W'(lo_q)) + (acc_q >>> FRAC_W);
		if (diff_q[TAB_W] && frac_q != '0) y_v = y_v + WRAP_CORR;
		y2_v  = y_v <<< 1;
		y31_v = neg_q ? -y2_v : y2_v;
	end

	always_comb begin
		if (acc_rnd > INT32_HI) z_v = INT32_HI[31:0];
		else if (acc_rnd < INT32_LO) z_v = INT32_LO[31:0];
		else z_v = acc_rnd[31:0];
	end

	always_comb begin
		res_v = (ACC_W'(mix_q) + OUT_RND) >>> OUT_SH;
		if (res_v > SAT_HI) sat_v = SAT_HI;
		else if (res_v < SAT_LO) sat_v = SAT_LO;
		else sat_v = res_v;
	end

	// control state, configuration and filter memories
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			step_q      <= ST_MDRV;
			out_valid_q <= 1'b0;
			drive_q     <= DRIVE_RST;
			ogain_q     <= OGAIN_RST;
			fb_q        <= FB_RST;
			wet_q       <= WET_RST;
			for (int i = 0; i < CHANNELS; i++) mem_q[i] <= '0;
		end else begin
			busy_q <= busy_n;
			step_q <= step_n;
			if (adv && ctl.act == ACT_OUT) out_valid_q <= 1'b1;
			else if (m_axis_tready) out_valid_q <= 1'b0;
			if (cfg_valid) begin
				case (cfg_index)
					CFG_DRIVE_GAIN:       drive_q <= cfg_data[DRIVE_W-1:0];
					CFG_OUTPUT_GAIN:      ogain_q <= cfg_data[OGAIN_W-1:0];
					CFG_LOWPASS_FEEDBACK: fb_q    <= cfg_data[FB_W-1:0];
					CFG_WET_MIX:          wet_q   <= cfg_data[WET_W-1:0];
					default: ;
				endcase
			end
			if (adv && ctl.act == ACT_ZST && ch_ok) mem_q[ch_q[CH_IDX_W-1:0]] <= z_v;
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (accept) begin
			sample_q <= s_axis_tdata[SAMPLE_BITS-1:0];
			ch_q     <= s_axis_tuser;
		end
		if (adv) begin
			case (ctl.acc_op)
				ACC_LOAD: acc_q <= prod[ACC_W-1:0];
				ACC_ADD:  acc_q <= acc_q + prod[ACC_W-1:0];
				default:  ;
			endcase
			case (ctl.act)
				ACT_ADDR: begin
					idx_q  <= addr_first;
					frac_q <= over ? '0 : mag[IDX_SHIFT-1 -: FRAC_W];
					neg_q  <= acc_q[ACC_W-1];
				end
				ACT_LO:    lo_q   <= rom_q;
				ACT_HI:    diff_q <= $signed({1'b0, rom_q}) - $signed({1'b0, lo_q});
				ACT_SHAPE: y31_q  <= y31_v[MUL_A_W-1:0];
				ACT_ZST:   z_q    <= z_v;
				ACT_WST:   w_q    <= acc_rnd[W_W-1:0];
				ACT_MIXR:  mix_q  <= acc_rnd[MIX_W-1:0];
				ACT_OUT: begin
					out_data_q <= ch_ok ? sat_v[SAMPLE_BITS-1:0] : sample_q;
					out_ch_q   <= ch_q;
				end
				default: ;
			endcase
		end
	end

	// an accepted word always starts the program at its first step
	a_accept_starts: assert property (@(posedge clk) disable iff (!arst_n)
		(s_axis_tvalid && s_axis_tready) |=> (busy_q && step_q == ST_MDRV))
		else $error("accepted word did not start the program");

	// a new result only comes out of the last program step
	a_result_from_out: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(busy_q && step_q == ST_OUT))
		else $error("result loaded outside the output step");

	// beyond the table end the fraction must be zero
	a_over_frac: assert property (@(posedge clk) disable iff (!arst_n)
		(busy_q && step_q == ST_LO) |-> (idx_q < ROM_AW'(TAB_DEPTH) || frac_q == '0))
		else $error("nonzero fraction at table end");

	// out-of-range channels never reach the memory update
	a_no_bypass_write: assert property (@(posedge clk) disable iff (!arst_n)
		(busy_q && step_q == ST_ZST) |-> ch_ok)
		else $error("bypassed word reached filter update");

endmodule
